@@ rtl/core/csmv_pkg.sv @@
// Package: shared widths, register codes and queue item types for the sparse matvec block.
`default_nettype none
package csmv_pkg;

  localparam int DATA_W          = 32;
  localparam int ACC_W           = 64;
  localparam int INDEX_W         = 10;
  localparam int ROW_W           = 16;
  localparam int YMODE_W         = 2;
  localparam int PADDR_W         = 4;
  localparam int PDATA_W         = 32;
  localparam int VEC_DEPTH_DEF   = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] REG_Y_MODE   = 2'd0;
  localparam logic [1:0] REG_SCALE    = 2'd1;
  localparam logic [1:0] REG_NUM_ROWS = 2'd2;

  localparam logic [YMODE_W-1:0] YM_ADD = 2'd1;
  localparam logic [YMODE_W-1:0] YM_SUB = 2'd2;

  localparam logic [YMODE_W-1:0]       Y_MODE_RESET   = 2'd0;
  localparam logic signed [DATA_W-1:0] SCALE_RESET    = 32'sd65536;
  localparam logic [ROW_W-1:0]         NUM_ROWS_RESET = 16'd1;

  localparam logic op_load  = 1'b0;
  localparam logic op_entry = 1'b1;

  typedef struct packed {
    logic wr_x;
    logic use_x;
    logic row_end;
  } csmv_ctl_t;

  typedef struct packed {
    csmv_ctl_t                  ctl;
    logic [INDEX_W-1:0]         index;
    logic signed [DATA_W-1:0]   value;
    logic signed [DATA_W-1:0]   y_value;
  } csmv_item_t;

endpackage
`default_nettype wire

@@ rtl/core/csr_sparse_matvec_axpy.sv @@
// A row-end request passes the front register, the queue, s1 to s5 and the result register.
// Throughput: one request per cycle unless results stall; the pipeline and queue sustain it.
// Results stall the whole back pipeline only while out_valid is high and out_ready is low.
// Reset (synchronous, rst high) clears the pipeline, queue, accumulator, row counter and
// registers (y_mode 0, scale_coeff 1.0, num_rows 1); the x store is not cleared.
// Top level: register port, front end, queue and back end.
`default_nettype none
module csr_sparse_matvec_axpy #(
  parameter int VEC_DEPTH   = csmv_pkg::VEC_DEPTH_DEF,
  parameter int QUEUE_DEPTH = csmv_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic                               op,
  input  wire logic [csmv_pkg::INDEX_W-1:0]       index,
  input  wire logic signed [csmv_pkg::DATA_W-1:0] value,
  input  wire logic                               has_entry,
  input  wire logic                               row_last,
  input  wire logic signed [csmv_pkg::DATA_W-1:0] y_value,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic [csmv_pkg::ROW_W-1:0]         row_index,
  output      logic signed [csmv_pkg::DATA_W-1:0] row_value,
  output      logic                               saturated,
  output      logic                               last_row,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [csmv_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [csmv_pkg::PDATA_W-1:0]       pwdata,
  output      logic [csmv_pkg::PDATA_W-1:0]       prdata,
  output      logic                               pready
);
  import csmv_pkg::*;

  logic [YMODE_W-1:0]       y_mode;
  logic signed [DATA_W-1:0] scale_coeff;
  logic [ROW_W-1:0]         num_rows;
  logic                     reg_wr;
  logic [1:0]               reg_sel;

  logic       push;
  csmv_item_t push_item;
  logic       q_full;
  logic       pop;
  logic       q_valid;
  csmv_item_t q_item;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      y_mode      <= Y_MODE_RESET;
      scale_coeff <= SCALE_RESET;
      num_rows    <= NUM_ROWS_RESET;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_Y_MODE:   y_mode      <= pwdata[YMODE_W-1:0];
        REG_SCALE:    scale_coeff <= pwdata[DATA_W-1:0];
        REG_NUM_ROWS: num_rows    <= pwdata[ROW_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_Y_MODE:   prdata = PDATA_W'(y_mode);
      REG_SCALE:    prdata = PDATA_W'(scale_coeff);
      REG_NUM_ROWS: prdata = PDATA_W'(num_rows);
      default:      prdata = '0;
    endcase
  end

  csmv_front #(
    .VEC_DEPTH(VEC_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .index    (index),
    .value    (value),
    .has_entry(has_entry),
    .row_last (row_last),
    .y_value  (y_value),
    .push     (push),
    .push_item(push_item),
    .q_full   (q_full)
  );

  csmv_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  csmv_back #(
    .VEC_DEPTH(VEC_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .y_mode     (y_mode),
    .scale_coeff(scale_coeff),
    .num_rows   (num_rows),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_index  (row_index),
    .row_value  (row_value),
    .saturated  (saturated),
    .last_row   (last_row)
  );

endmodule
`default_nettype wire

@@ rtl/core/csmv_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module csmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/csmv_front.sv @@
// Front end: accept requests, classify them and hand them to the queue.
`default_nettype none
module csmv_front #(
  parameter int VEC_DEPTH = csmv_pkg::VEC_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic                             op,
  input  wire logic [csmv_pkg::INDEX_W-1:0]     index,
  input  wire logic signed [csmv_pkg::DATA_W-1:0] value,
  input  wire logic                             has_entry,
  input  wire logic                             row_last,
  input  wire logic signed [csmv_pkg::DATA_W-1:0] y_value,
  output      logic                             push,
  output      csmv_pkg::csmv_item_t             push_item,
  input  wire logic                             q_full
);
  import csmv_pkg::*;

  logic       f_valid;
  logic       in_range;
  csmv_item_t item_next;

  assign in_range = (32'(index) < 32'(VEC_DEPTH));
  assign push     = f_valid && !q_full;
  assign in_ready = !f_valid || !q_full;

  always_comb begin
    item_next.ctl.wr_x    = (op == op_load) && in_range;
    item_next.ctl.use_x   = (op == op_entry) && has_entry && in_range;
    item_next.ctl.row_end = (op == op_entry) && row_last;
    item_next.index       = index;
    item_next.value       = value;
    item_next.y_value     = y_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      push_item <= item_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/csmv_queue.sv @@
// Short FIFO between the front end and the back end.
`default_nettype none
module csmv_queue #(
  parameter int DEPTH = csmv_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire csmv_pkg::csmv_item_t push_item,
  output      logic                 full,
  input  wire logic                 pop,
  output      logic                 q_valid,
  output      csmv_pkg::csmv_item_t q_item
);
  import csmv_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csmv_item_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/csmv_back.sv @@
// Back end: x store, product and accumulate pipeline, row-end scaling and result register.
`default_nettype none
module csmv_back #(
  parameter int VEC_DEPTH = csmv_pkg::VEC_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               q_valid,
  input  wire csmv_pkg::csmv_item_t               q_item,
  output      logic                               pop,
  input  wire logic [csmv_pkg::YMODE_W-1:0]       y_mode,
  input  wire logic signed [csmv_pkg::DATA_W-1:0] scale_coeff,
  input  wire logic [csmv_pkg::ROW_W-1:0]         num_rows,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic [csmv_pkg::ROW_W-1:0]         row_index,
  output      logic signed [csmv_pkg::DATA_W-1:0] row_value,
  output      logic                               saturated,
  output      logic                               last_row
);
  import csmv_pkg::*;

  localparam int AW = $clog2(VEC_DEPTH);
  localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;
  localparam int TW = ACC_W - 16 + 2;
  localparam int PW = ACC_W - 16 + 1;

  logic                       adv;
  logic [XW-1:0]              idx_ext;
  logic [DATA_W-1:0]          ram_rdata;
  logic signed [DATA_W-1:0]   x_data;

  logic                       s1_valid;
  logic                       s1_use_x;
  logic                       s1_end;
  logic signed [DATA_W-1:0]   s1_value;
  logic signed [DATA_W-1:0]   s1_y;

  logic                       s2_valid;
  logic                       s2_end;
  logic signed [ACC_W-1:0]    s2_prod;
  logic signed [DATA_W-1:0]   s2_y;
  logic signed [ACC_W-1:0]    prod_c;

  logic signed [ACC_W-1:0]    acc;
  logic                       acc_sat;
  logic [ACC_W:0]             acc_sum;
  logic                       acc_ovf;
  logic signed [ACC_W-1:0]    acc_next;

  logic                       s3_valid;
  logic signed [ACC_W-1:0]    s3_acc;
  logic                       s3_sat;
  logic signed [DATA_W-1:0]   s3_y;

  logic [TW-1:0]              y_term;
  logic [TW-1:0]              t_sum;
  logic                       t_fits;
  logic signed [DATA_W-1:0]   t_sat;

  logic                       s4_valid;
  logic signed [DATA_W-1:0]   s4_t;
  logic                       s4_sat;

  logic                       s5_valid;
  logic signed [ACC_W-1:0]    s5_prod;
  logic                       s5_sat;
  logic signed [ACC_W-1:0]    prod2_c;

  logic [PW-1:0]              r_sum;
  logic                       r_fits;
  logic signed [DATA_W-1:0]   r_sat;

  logic [ROW_W-1:0]           row_counter;
  logic                       row_is_last;

  assign adv     = !out_valid || out_ready;
  assign pop     = adv && q_valid;
  assign idx_ext = XW'(q_item.index);
  assign x_data  = ram_rdata;

  csmv_ram #(
    .WIDTH(DATA_W),
    .DEPTH(VEC_DEPTH)
  ) u_x_store (
    .clk  (clk),
    .we   (pop && q_item.ctl.wr_x),
    .waddr(idx_ext[AW-1:0]),
    .wdata(q_item.value),
    .re   (pop && q_item.ctl.use_x),
    .raddr(idx_ext[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign prod_c  = s1_value * x_data;
  assign prod2_c = s4_t * scale_coeff;

  always_comb begin
    acc_sum  = {acc[ACC_W-1], acc} + {s2_prod[ACC_W-1], s2_prod};
    acc_ovf  = acc_sum[ACC_W] != acc_sum[ACC_W-1];
    acc_next = acc_sum[ACC_W-1:0];
    if (acc_ovf) begin
      acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_comb begin
    y_term = '0;
    priority if (y_mode == YM_ADD) begin
      y_term = TW'(s3_y);
    end else if (y_mode == YM_SUB) begin
      y_term = -TW'(s3_y);
    end else begin
      y_term = '0;
    end
    t_sum  = {{2{s3_acc[ACC_W-1]}}, s3_acc[ACC_W-1:16]} + y_term + TW'(s3_acc[15]);
    t_fits = (&t_sum[TW-1:DATA_W-1]) || !(|t_sum[TW-1:DATA_W-1]);
    t_sat  = t_sum[DATA_W-1:0];
    if (!t_fits) begin
      t_sat = t_sum[TW-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_comb begin
    r_sum  = {s5_prod[ACC_W-1], s5_prod[ACC_W-1:16]} + PW'(s5_prod[15]);
    r_fits = (&r_sum[PW-1:DATA_W-1]) || !(|r_sum[PW-1:DATA_W-1]);
    r_sat  = r_sum[DATA_W-1:0];
    if (!r_fits) begin
      r_sat = r_sum[PW-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign row_is_last = ({1'b0, row_counter} + 17'd1) >= {1'b0, num_rows};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      s4_valid    <= 1'b0;
      s5_valid    <= 1'b0;
      out_valid   <= 1'b0;
      acc         <= '0;
      acc_sat     <= 1'b0;
      row_counter <= '0;
    end else if (adv) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid && s2_end;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
      if (s2_valid) begin
        if (s2_end) begin
          acc     <= '0;
          acc_sat <= 1'b0;
        end else begin
          acc     <= acc_next;
          acc_sat <= acc_sat || acc_ovf;
        end
      end
      if (s5_valid) begin
        row_counter <= row_is_last ? '0 : row_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_use_x <= q_item.ctl.use_x;
      s1_end   <= q_item.ctl.row_end;
      s1_value <= q_item.value;
      s1_y     <= q_item.y_value;
      s2_end   <= s1_end;
      s2_y     <= s1_y;
      s2_prod  <= s1_use_x ? prod_c : 64'sd0;
      s3_acc   <= acc_next;
      s3_sat   <= acc_sat || acc_ovf;
      s3_y     <= s2_y;
      s4_t     <= t_sat;
      s4_sat   <= s3_sat || !t_fits;
      s5_prod  <= prod2_c;
      s5_sat   <= s4_sat;
      if (s5_valid) begin
        row_index <= row_counter;
        row_value <= r_sat;
        saturated <= s5_sat || !r_fits;
        last_row  <= row_is_last;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/csmv_checker.sv @@
// Port-level checker for the sparse matvec block and its bind to the top level.
`default_nettype none
module csmv_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               op,
  input wire logic                               row_last,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [csmv_pkg::ROW_W-1:0]         row_index,
  input wire logic signed [csmv_pkg::DATA_W-1:0] row_value,
  input wire logic                               last_row,
  input wire logic                               psel,
  input wire logic                               penable,
  input wire logic                               pwrite,
  input wire logic [csmv_pkg::PADDR_W-1:0]       paddr,
  input wire logic [csmv_pkg::PDATA_W-1:0]       pwdata,
  input wire logic                               pready
);
  import csmv_pkg::*;

  logic [7:0]       pending;
  logic [ROW_W-1:0] exp_row;
  logic [ROW_W-1:0] rows_copy;
  logic             end_in;
  logic             res_out;

  assign end_in  = in_valid && in_ready && (op == op_entry) && row_last;
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      exp_row   <= '0;
      rows_copy <= NUM_ROWS_RESET;
    end else begin
      if (end_in && !res_out) begin
        pending <= pending + 1'b1;
      end else if (res_out && !end_in) begin
        pending <= pending - 1'b1;
      end
      if (res_out) begin
        exp_row <= last_row ? '0 : row_index + 1'b1;
      end
      if (psel && penable && pwrite && pready && (paddr[3:2] == REG_NUM_ROWS)) begin
        rows_copy <= pwdata[ROW_W-1:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_value) && $stable(row_index))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0)
    else $error("result without a row-end request");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> row_index == exp_row)
    else $error("row number out of sequence");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_row == (({1'b0, row_index} + 17'd1) >= {1'b0, rows_copy}))
    else $error("last row mark disagrees with row count");

endmodule

bind csr_sparse_matvec_axpy csmv_checker u_csmv_checker (.*);
`default_nettype wire
